// ===== sv/tafof_pkg.sv =====
`timescale 1ns / 1ps

package tafof_pkg;

   localparam int SAMPLE_WIDTH    = 16;
   localparam int COEFF_FRAC_BITS = 16;
   localparam int COEFF_WIDTH     = COEFF_FRAC_BITS + 1;
   localparam int CSR_INDEX_WIDTH = 1;

   // Coefficient value of exactly one.
   localparam logic [COEFF_WIDTH-1:0] COEFF_ONE = COEFF_WIDTH'(2 ** COEFF_FRAC_BITS);

   typedef enum logic {
      MODE_HIGH_PASS = 1'b0,
      MODE_LOW_PASS  = 1'b1
   } filter_mode_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_FILTER_MODE     = 1'b0,
      CSR_SMOOTHING_COEFF = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] sample_x;
      logic signed [SAMPLE_WIDTH-1:0] sample_y;
      logic signed [SAMPLE_WIDTH-1:0] sample_z;
   } req_data_type;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] filtered_x;
      logic signed [SAMPLE_WIDTH-1:0] filtered_y;
      logic signed [SAMPLE_WIDTH-1:0] filtered_z;
   } rsp_data_type;

   typedef struct packed {
      filter_mode_type        filter_mode;
      logic [COEFF_WIDTH-1:0] smoothing_coeff;
   } cfg_type;

endpackage

// ===== sv/tafof_csr.sv =====
`timescale 1ns / 1ps

module tafof_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   input  logic                                  csr_ready,
   input  logic [tafof_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [tafof_pkg::COEFF_WIDTH-1:0]     csr_data,
   output tafof_pkg::cfg_type                    cfg
);

   tafof_pkg::cfg_type cfg_ff;
   tafof_pkg::cfg_type cfg_in;
   tafof_pkg::csr_index_type index;

   assign index = tafof_pkg::csr_index_type'(csr_index);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (index)
            tafof_pkg::CSR_FILTER_MODE: begin
               cfg_in.filter_mode = tafof_pkg::filter_mode_type'(csr_data[0]);
            end
            tafof_pkg::CSR_SMOOTHING_COEFF: begin
               // Anything above one is clamped to exactly one.
               if (csr_data > tafof_pkg::COEFF_ONE) begin
                  cfg_in.smoothing_coeff = tafof_pkg::COEFF_ONE;
               end else begin
                  cfg_in.smoothing_coeff = csr_data;
               end
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.filter_mode     <= tafof_pkg::MODE_HIGH_PASS;
         cfg_ff.smoothing_coeff <= tafof_pkg::COEFF_ONE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== sv/tafof_axis.sv =====
`timescale 1ns / 1ps

module tafof_axis (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       update,
   input  tafof_pkg::cfg_type                         cfg,
   input  logic signed [tafof_pkg::SAMPLE_WIDTH-1:0]  sample,
   output logic signed [tafof_pkg::SAMPLE_WIDTH-1:0]  filtered
);

   localparam int SW         = tafof_pkg::SAMPLE_WIDTH;
   localparam int FB         = tafof_pkg::COEFF_FRAC_BITS;
   localparam int DIFF_WIDTH = SW + 2;
   localparam int PROD_WIDTH = DIFF_WIDTH + tafof_pkg::COEFF_WIDTH + 1;
   localparam int ACC_WIDTH  = PROD_WIDTH + 1;

   localparam logic signed [ACC_WIDTH-1:0] ROUND_HALF = ACC_WIDTH'(2 ** (FB - 1));
   localparam logic signed [ACC_WIDTH-1:0] SAT_MAX    = ACC_WIDTH'(2 ** (SW - 1) - 1);
   localparam logic signed [ACC_WIDTH-1:0] SAT_MIN    = ACC_WIDTH'(-(2 ** (SW - 1)));

   logic signed [SW-1:0]                      last_output_ff;
   logic signed [SW-1:0]                      last_sample_ff;
   logic signed [DIFF_WIDTH-1:0]              diff;
   logic signed [tafof_pkg::COEFF_WIDTH:0]    coeff_s;
   logic signed [PROD_WIDTH-1:0]              prod;
   logic signed [ACC_WIDTH-1:0]               base;
   logic signed [ACC_WIDTH-1:0]               sum;
   logic signed [ACC_WIDTH-1:0]               shifted;

   // Low-pass a*x + (1-a)*y is folded into a*(x - y) + y, so both modes
   // share one multiplier.
   always_comb begin
      coeff_s = signed'({1'b0, cfg.smoothing_coeff});
      if (cfg.filter_mode == tafof_pkg::MODE_LOW_PASS) begin
         diff = DIFF_WIDTH'(sample) - DIFF_WIDTH'(last_output_ff);
         base = ACC_WIDTH'(last_output_ff) <<< FB;
      end else begin
         diff = DIFF_WIDTH'(last_output_ff) + DIFF_WIDTH'(sample)
                - DIFF_WIDTH'(last_sample_ff);
         base = '0;
      end
      prod    = PROD_WIDTH'(diff) * PROD_WIDTH'(coeff_s);
      sum     = ACC_WIDTH'(prod) + base + ROUND_HALF;
      shifted = sum >>> FB;
      if (shifted > SAT_MAX) begin
         filtered = SW'(SAT_MAX);
      end else if (shifted < SAT_MIN) begin
         filtered = SW'(SAT_MIN);
      end else begin
         filtered = SW'(shifted);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_output_ff <= '0;
         last_sample_ff <= '0;
      end else if (update) begin
         last_output_ff <= filtered;
         last_sample_ff <= sample;
      end
   end

endmodule

// ===== sv/three_axis_first_order_filter_core.sv =====
`timescale 1ns / 1ps
// A sample passes through an input stage and a result register before its result is offered.
// Throughput: one sample per cycle while the result register is not stalled; the per-axis
// multiply-add that updates the filter state sets that figure.
// Reset (synchronous, active high) clears the filter state and both stages,
// and sets high-pass mode with a coefficient of one.

module three_axis_first_order_filter_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  tafof_pkg::req_data_type               req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output tafof_pkg::rsp_data_type               rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [tafof_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [tafof_pkg::COEFF_WIDTH-1:0]     csr_data
);

   tafof_pkg::cfg_type      cfg;
   tafof_pkg::req_data_type req_data_ff;
   tafof_pkg::rsp_data_type rsp_data_ff;
   tafof_pkg::rsp_data_type rsp_data_in;
   logic                    req_valid_ff;
   logic                    req_valid_in;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic                    out_free;
   logic                    advance;
   logic                    accept;

   assign csr_ready = 1'b1;

   tafof_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign advance      = req_valid_ff && out_free;
   assign req_stall    = req_valid_ff && !out_free;
   assign accept       = req_valid && !req_stall;
   assign req_valid_in = accept || (req_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   tafof_axis u_axis_x (
      .clock    (clock),
      .reset    (reset),
      .update   (advance),
      .cfg      (cfg),
      .sample   (req_data_ff.sample_x),
      .filtered (rsp_data_in.filtered_x)
   );

   tafof_axis u_axis_y (
      .clock    (clock),
      .reset    (reset),
      .update   (advance),
      .cfg      (cfg),
      .sample   (req_data_ff.sample_y),
      .filtered (rsp_data_in.filtered_y)
   );

   tafof_axis u_axis_z (
      .clock    (clock),
      .reset    (reset),
      .update   (advance),
      .cfg      (cfg),
      .sample   (req_data_ff.sample_z),
      .filtered (rsp_data_in.filtered_z)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A full input stage facing a blocked result register must hold off the sender.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid_ff && rsp_valid_ff && rsp_stall) |-> req_stall)
      else $error("input stage overrun while result register is blocked");

   // Every accepted transfer occupies the input stage on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      accept |=> req_valid_ff)
      else $error("accepted sample lost from input stage");

   // Every sample leaving the input stage shows up as a result.
   assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("filtered result lost between stages");

   // The stored coefficient never exceeds one.
   assert property (@(posedge clock) disable iff (reset)
      cfg.smoothing_coeff <= tafof_pkg::COEFF_ONE)
      else $error("coefficient register above one");

endmodule
